@@ design/led_color_fade_serializer_macros.svh @@
// Assertion macros shared by the LED colour fade serializer modules.
// Depends on nothing; each user supplies signals named clk and rst_n.
`ifndef LED_COLOR_FADE_SERIALIZER_MACROS_SVH
`define LED_COLOR_FADE_SERIALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lcfs_pkg.sv @@
// Shared types and constants for the LED colour fade serializer.
// No dependencies; imported by every module of the block.
package lcfs_pkg;

  localparam int CHAN_W            = 8;
  localparam int NUM_CHAN          = 3;
  localparam int COLOR_W           = CHAN_W * NUM_CHAN;
  localparam int FRAC_W            = 9;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int BITS_PER_LED      = COLOR_W;
  localparam int CNT_W             = $clog2(BITS_PER_LED + 1);
  localparam int PROD_W            = CHAN_W + FRAC_W;
  localparam int SUM_W             = PROD_W + 1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

  // One input item: an LED's start and end colour and its frame marker.
  typedef struct packed {
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
    logic               frame_end;
  } in_item_t;

  // One result item: a single serial bit with its markers.
  typedef struct packed {
    logic data_bit;
    logic last_bit;
    logic frame_done;
  } out_item_t;

  // Load request from the merge point into the serializer.
  typedef struct packed {
    logic               load;
    logic               frame_end;
    logic [COLOR_W-1:0] word;
  } ser_load_t;

endpackage

@@ design/led_color_fade_serializer.sv @@
// LED colour fade serializer top level: three channel lanes and serializer.
// Depends on lcfs_pkg, lcfs_lane, lcfs_serializer and the macros header.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one LED's start and end
//   colour plus a frame-end marker. Each channel is faded by the fraction in
//   the configuration register (cfg_wr_en/cfg_wr_data, written when idle).
//   The output channel (out_valid/out_ready/out_data) gives 24 transfers per
//   LED, red, green then blue, most significant bit first; the 24th bit
//   carries last_bit, and frame_done when the LED closed the frame.
//   The first bit is offered once the lane multiply register has loaded at
//   the input transfer and the shift word has then loaded from it; a busy
//   shift register holds the LED in the lane registers in between.
//   The shift register sends one bit per cycle while out_ready is high; the
//   next LED waits in the lane registers so the bit stream runs without gaps.
//   Reset clears the fraction to zero and empties both stages.
//   A stalled receiver holds the current bit; once the lane stage is also
//   full, in_ready drops until the shift register frees up.
`include "led_color_fade_serializer_macros.svh"

module led_color_fade_serializer
  import lcfs_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [FRAC_W-1:0] cfg_wr_data
);

  logic [FRAC_W-1:0] fade_fraction_r;
  logic              lane_valid_r, lane_valid_nxt;
  logic              lane_frame_r;
  logic              in_xfer;
  logic              can_load;
  logic [CHAN_W-1:0] chan_res [NUM_CHAN];
  ser_load_t         ld;

  // Fraction register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_fraction_r <= '0;
    end else if (cfg_wr_en) begin
      fade_fraction_r <= cfg_wr_data;
    end
  end

  // Lane stage occupancy and handover to the serializer.
  always_comb begin
    ld.load        = lane_valid_r && can_load;
    ld.frame_end   = lane_frame_r;
    ld.word        = {chan_res[2], chan_res[1], chan_res[0]};
    in_ready       = !lane_valid_r || can_load;
    in_xfer        = in_valid && in_ready;
    lane_valid_nxt = in_xfer || (lane_valid_r && !can_load);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_valid_r <= 1'b0;
    end else begin
      lane_valid_r <= lane_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lane_frame_r <= in_data.frame_end;
    end
  end

  // One lane per colour channel; lane 2 is red, lane 0 is blue.
  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
    lcfs_lane #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
      .clk       (clk),
      .load      (in_xfer),
      .start_chan(in_data.start_color[i*CHAN_W +: CHAN_W]),
      .end_chan  (in_data.end_color[i*CHAN_W +: CHAN_W]),
      .fraction  (fade_fraction_r),
      .chan_out  (chan_res[i])
    );
  end

  // Shift register with merged colour word.
  lcfs_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // The lane stage only empties into the serializer or holds.
  `LCFS_ASSERT_NEXT(a_lane_hold, lane_valid_r && !can_load, lane_valid_r, "lane item lost")
  `LCFS_ASSERT_NEXT(a_load_fills, ld.load, out_valid, "load did not start output")
  `LCFS_ASSERT_NOW(a_ready_free, !lane_valid_r, in_ready, "empty lane stage refused input")

endmodule

@@ design/lcfs_lane.sv @@
// One colour channel of the fade: registered multiply, then add and clamp.
// Depends on lcfs_pkg.
module lcfs_lane
  import lcfs_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              load,
  input  logic [CHAN_W-1:0] start_chan,
  input  logic [CHAN_W-1:0] end_chan,
  input  logic [FRAC_W-1:0] fraction,
  output logic [CHAN_W-1:0] chan_out
);

  logic [CHAN_W:0]   diff;
  logic              neg;
  logic [CHAN_W-1:0] mag;
  logic [PROD_W-1:0] prod_r;
  logic [CHAN_W-1:0] start_r;
  logic              neg_r;
  logic [PROD_W-1:0] quot;
  logic [SUM_W-1:0]  sum;

  // Magnitude and sign of the colour step.
  always_comb begin
    diff = {1'b0, end_chan} - {1'b0, start_chan};
    neg  = diff[CHAN_W];
    mag  = neg ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
  end

  // Scale the step by the fraction; the product is registered.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r  <= PROD_W'(mag) * PROD_W'(fraction);
      start_r <= start_chan;
      neg_r   <= neg;
    end
  end

  // Truncate towards zero, apply the step and clamp to the channel range.
  always_comb begin
    quot = prod_r >> FRACTION_BITS;
    if (neg_r) begin
      sum = SUM_W'(start_r) - SUM_W'(quot);
    end else begin
      sum = SUM_W'(start_r) + SUM_W'(quot);
    end
    if (sum[SUM_W-1]) begin
      chan_out = '0;
    end else if (sum[SUM_W-2:CHAN_W] != '0) begin
      chan_out = CHAN_MAX;
    end else begin
      chan_out = sum[CHAN_W-1:0];
    end
  end

endmodule

@@ design/lcfs_serializer.sv @@
// Merged colour word shift register: sends 24 bits MSB first per LED.
// Depends on lcfs_pkg and led_color_fade_serializer_macros.svh.
`include "led_color_fade_serializer_macros.svh"

module lcfs_serializer
  import lcfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ser_load_t ld,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [COLOR_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]   bits_left_r, bits_left_nxt;
  logic               frame_r, frame_nxt;
  logic               xfer;

  // A word may load when empty or as the current word's last bit transfers.
  always_comb begin
    out_valid           = (bits_left_r != '0);
    xfer                = out_valid && out_ready;
    can_load            = !out_valid || (xfer && (bits_left_r == CNT_W'(1)));
    out_data.data_bit   = shift_r[COLOR_W-1];
    out_data.last_bit   = (bits_left_r == CNT_W'(1));
    out_data.frame_done = out_data.last_bit && frame_r;
  end

  // Load a fresh word or shift after each transfer.
  always_comb begin
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    frame_nxt     = frame_r;
    if (ld.load) begin
      shift_nxt     = ld.word;
      bits_left_nxt = CNT_W'(BITS_PER_LED);
      frame_nxt     = ld.frame_end;
    end else if (xfer) begin
      shift_nxt     = {shift_r[COLOR_W-2:0], 1'b0};
      bits_left_nxt = bits_left_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      bits_left_r <= '0;
      frame_r     <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      frame_r     <= frame_nxt;
    end
  end

  // Checks on the bit counter and load timing.
  `LCFS_ASSERT_NOW(a_load_free, ld.load, can_load, "serializer loaded while still busy")
  `LCFS_ASSERT_NEXT(a_load_count, ld.load, bits_left_r == CNT_W'(BITS_PER_LED), "load did not arm count")
  `LCFS_ASSERT_NOW(a_count_range, 1'b1, bits_left_r <= CNT_W'(BITS_PER_LED), "bit count out of range")
  `LCFS_ASSERT_NEXT(a_drain_step, xfer && !ld.load, bits_left_r == $past(bits_left_r) - CNT_W'(1), "count did not step")

endmodule
